[rtl/core/oal_pkg.sv]
// shared types and constants for the ordered array list engine
// request and response payload structs, opcode and status codes, cell control
// no dependencies
package oal_pkg;

   localparam int DATA_W    = 32;
   localparam int POS_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int GROUP     = 8;
   localparam int GROUP_LOG = 3;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_RANGE    = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_HOLD
   } fsm_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   found_position;
      logic [COUNT_W-1:0] element_count;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic ins;
      logic del;
      logic cmp;
   } cell_ctrl_type;

endpackage

[rtl/core/oal_cell.sv]
// one storage cell of the list row: holds one entry and its match flag
// shifts with its neighbors on insert and delete, compares on find
// depends on oal_pkg
module oal_cell #(
   parameter int IDX_W = 6,
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  oal_pkg::cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]              pos,
   input  logic [CNT_W-1:0]              count,
   input  logic [oal_pkg::DATA_W-1:0]    value,
   input  logic [oal_pkg::DATA_W-1:0]    left_data,
   input  logic [oal_pkg::DATA_W-1:0]    right_data,
   output logic [oal_pkg::DATA_W-1:0]    data,
   output logic                          match
);
   import oal_pkg::*;

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   // entry update: take the new value, the lower neighbor or the upper neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (MY_POS == pos) begin
            entry_in = value;
         end else if (MY_POS > pos) begin
            entry_in = left_data;
         end
      end else if (ctrl.del) begin
         if (MY_POS >= pos) begin
            entry_in = right_data;
         end
      end
   end

   // compare against the search value, only cells below the count take part
   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp) begin
         match_in = (MY_CNT < count) && (entry_ff == value);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign data  = entry_ff;
   assign match = match_ff;

endmodule

[rtl/core/ordered_array_list_engine_unit.sv]
// Ordered array list engine: a positional list of signed 32-bit values held in
// a row of CAPACITY cells. Requests arrive on req_valid/req_stall/req_data and
// one result per request leaves on rsp_valid/rsp_stall/rsp_data.
// Insert, delete and clear act in the transfer cycle: insert and delete update
// the row of cells and the count, clear resets only the count. Their result is
// registered into the output register. Insert and delete shift every later cell
// by one position in parallel. Find compares all cells in the transfer cycle,
// then a scanner walks the match flags eight cells per cycle, lowest first, and
// stops at the first hit or after the last group. A new request is taken once
// the previous one has its result, so insert, delete and clear run one per
// cycle while the receiver does not stall, and a find holds the input for its
// whole scan.
// When the receiver stalls, the waiting result holds in the output register;
// one more request can complete into a hold register, after which req_stall
// stays high until the output register frees up.
// Reset empties the list (count zero) and drops any pending result; the entry
// cells are not cleared and are never read before they are written.
// The element count and found position are reported masked to their fields.
module ordered_array_list_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oal_pkg::rsp_type rsp_data
);
   import oal_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CW_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int NGRP   = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PAD_W  = NGRP * GROUP;
   localparam int FPR_W  = GRP_W + GROUP_LOG;
   localparam int FP_W   = (FPR_W > POS_W) ? FPR_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NGRP - 1);

   fsm_type           state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   rsp_type           pend_ff, pend_in;

   logic              accept;
   logic              out_load;
   cell_ctrl_type     ctrl;
   logic [CMP_W-1:0]  pos_w, cnt_w;
   logic [IDX_W-1:0]  pos_idx;
   logic [CW_W-1:0]   count_wide;

   logic              res_valid;
   rsp_type           res_data;
   logic              src_valid;
   rsp_type           src_data;

   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [PAD_W-1:0]    match_pad;
   logic [GROUP-1:0]    grp_bits;
   logic [GROUP_LOG-1:0] enc;
   logic                grp_hit;
   logic [FP_W-1:0]     fp_wide;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != FSM_IDLE);
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   assign pos_w   = CMP_W'(req_data.position);
   assign cnt_w   = CMP_W'(count_ff);
   assign pos_idx = pos_w[IDX_W-1:0];

   // row of cells, each handing its entry to both neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = req_data.value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      oal_cell #(
         .IDX_W (IDX_W),
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (pos_idx),
         .count      (count_ff),
         .value      (req_data.value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (match_vec[i])
      );
   end

   // match scan: one group of eight flags per cycle, lowest hit wins
   assign match_pad = PAD_W'(match_vec);
   assign grp_bits  = match_pad[{grp_ff, {GROUP_LOG{1'b0}}} +: GROUP];
   assign grp_hit   = |grp_bits;

   always_comb begin
      enc = '0;
      for (int i = GROUP - 1; i >= 0; i--) begin
         if (grp_bits[i]) begin
            enc = GROUP_LOG'(i);
         end
      end
   end

   assign fp_wide = FP_W'({grp_ff, enc});

   // sequencer: request decode, scan steps and result hand-off
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      grp_in     = grp_ff;
      pend_in    = pend_ff;
      ctrl       = '0;
      res_valid  = 1'b0;
      res_data   = '0;
      count_wide = '0;
      src_valid  = 1'b0;
      src_data   = pend_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               res_valid       = 1'b1;
               res_data.status = STAT_OK;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        res_data.status = STAT_FULL;
                     end else if (pos_w > cnt_w) begin
                        res_data.status = STAT_RANGE;
                     end else begin
                        ctrl.ins = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        res_data.status = STAT_RANGE;
                     end else begin
                        ctrl.del = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        res_data.status = STAT_EMPTY;
                     end else begin
                        ctrl.cmp  = 1'b1;
                        res_valid = 1'b0;
                        grp_in    = '0;
                        state_in  = FSM_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
               count_wide             = CW_W'(count_in);
               res_data.element_count = count_wide[COUNT_W-1:0];
            end
         end
         FSM_SCAN: begin
            count_wide             = CW_W'(count_ff);
            res_data.element_count = count_wide[COUNT_W-1:0];
            if (grp_hit) begin
               res_valid               = 1'b1;
               res_data.status         = STAT_OK;
               res_data.found_position = fp_wide[POS_W-1:0];
               state_in                = FSM_IDLE;
            end else if (grp_ff == LAST_GRP) begin
               res_valid       = 1'b1;
               res_data.status = STAT_NOTFOUND;
               state_in        = FSM_IDLE;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end
         FSM_HOLD: begin
            src_valid = 1'b1;
            if (out_load) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      // a fresh result goes straight out or parks in the hold register
      if (res_valid) begin
         src_valid = 1'b1;
         src_data  = res_data;
         if (!out_load) begin
            pend_in  = res_data;
            state_in = FSM_HOLD;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = src_valid;
         if (src_valid) begin
            rsp_data_in = src_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
